// ===== src/assert_macros.svh =====
// Shared assertion macros for the palette mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ODPM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ODPM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/odpm_pkg.sv =====
package odpm_pkg;

    localparam int PALETTE_ENTRIES_DEFAULT = 256;
    localparam int CHAN_W = 8;
    localparam int SIX_W = 6;
    localparam int WORD_W = 3 * SIX_W;
    localparam int SQ_W = 12;
    localparam int DIST_W = 14;
    localparam int OUT_W = 8;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MAP = 1'b1;

    // Ordered-dither offsets, indexed by column phase then row phase
    localparam logic signed [4:0] DITHER_OFFSET [4][4] = '{
        '{-5'sd7,  5'sd1, -5'sd5,  5'sd3},
        '{ 5'sd5, -5'sd3,  5'sd7, -5'sd1},
        '{-5'sd4,  5'sd4, -5'sd6,  5'sd2},
        '{ 5'sd8,  5'sd0,  5'sd6, -5'sd2}
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_HOLD
    } odpm_state_t;

    // Request from the front end to the search unit
    typedef struct packed {
        logic              start;
        logic              wr_en;
        logic [CHAN_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_word;
        logic [SIX_W-1:0]  r6;
        logic [SIX_W-1:0]  g6;
        logic [SIX_W-1:0]  b6;
    } odpm_req_t;

    // Status from the search unit
    typedef struct packed {
        logic busy;
        logic done;
    } odpm_stat_t;

    // Add the dither offset when enabled, clamp to 0..255, keep the top six bits
    function automatic logic [SIX_W-1:0] dither_six(
        input logic [CHAN_W-1:0] chan,
        input logic [1:0]        col,
        input logic [1:0]        row,
        input logic              mode
    );
        logic signed [4:0] off;
        logic signed [9:0] sum;
        logic [CHAN_W-1:0] clamped;
        off = DITHER_OFFSET[col][row];
        sum = $signed({2'b00, chan}) + $signed({{5{off[4]}}, off});
        if (!mode) begin
            clamped = chan;
        end else if (sum < 0) begin
            clamped = 8'd0;
        end else if (sum > 10'sd255) begin
            clamped = 8'd255;
        end else begin
            clamped = sum[7:0];
        end
        return clamped[7:2];
    endfunction

    // Squared difference of two six-bit channels
    function automatic logic [SQ_W-1:0] sq_diff(
        input logic [SIX_W-1:0] a,
        input logic [SIX_W-1:0] b
    );
        logic signed [6:0]  d;
        logic signed [13:0] p;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        p = d * d;
        return p[SQ_W-1:0];
    endfunction

endpackage

// ===== src/odpm_search.sv =====
`include "assert_macros.svh"

module odpm_search #(
    parameter int PALETTE_ENTRIES = odpm_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  odpm_pkg::odpm_req_t            req,
    input  logic                           take,
    output odpm_pkg::odpm_stat_t           stat,
    output logic [odpm_pkg::OUT_W-1:0]     result
);
    import odpm_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    // Palette memory, one 18-bit word per entry
    logic [WORD_W-1:0] mem [PALETTE_ENTRIES];

    odpm_state_t state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic v1_reg, v2_reg, last1_reg, last2_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic [SIX_W-1:0] r6_reg, g6_reg, b6_reg;
    logic [SQ_W-1:0] sqr_reg, sqg_reg, sqb_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [DIST_W-1:0] cand_dist;
    logic issue;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[IDX_W-1:0]] <= req.wr_word;
        end
        rd_word_reg <= mem[addr_reg];
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        issue = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                addr_next = '0;
                if (req.start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                issue = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (v2_reg && last2_reg)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            addr_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            last1_reg <= 1'b0;
            last2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            v1_reg <= issue;
            last1_reg <= issue && (addr_reg == LAST_IDX);
            v2_reg <= v1_reg;
            last2_reg <= v1_reg && last1_reg;
        end
    end

    // Sum the squares of the current entry
    assign cand_dist = DIST_W'(sqr_reg) + DIST_W'(sqg_reg) + DIST_W'(sqb_reg);

    // Latch the pixel, square the differences, keep the nearest entry
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.start)
        begin
            r6_reg <= req.r6;
            g6_reg <= req.g6;
            b6_reg <= req.b6;
        end
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        sqr_reg <= sq_diff(rd_word_reg[17:12], r6_reg);
        sqg_reg <= sq_diff(rd_word_reg[11:6], g6_reg);
        sqb_reg <= sq_diff(rd_word_reg[5:0], b6_reg);
        if (v2_reg && (idx2_reg == '0 || cand_dist < best_dist_reg))
        begin
            best_dist_reg <= cand_dist;
            best_idx_reg <= idx2_reg;
        end
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_HOLD);
    assign result = OUT_W'(best_idx_reg);

    `ODPM_ASSERT(a_idle_stays, (state_reg == S_IDLE && !req.start) |=> (state_reg == S_IDLE), "search left idle without a start")
    `ODPM_ASSERT(a_last_done, (v2_reg && last2_reg) |=> (state_reg == S_HOLD), "last entry compared but no result held")
    `ODPM_ASSERT_ALWAYS(a_read_in_scan, v1_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN), "read data outside of a scan")

endmodule

// ===== src/ordered_dither_palette_mapper_unit.sv =====
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   opcode, entry_index, red, green, blue,
//                                          column_phase, row_phase
// out       output     out_valid/out_stall palette_index
// cfg       input      cfg_wr_en           cfg_wr_data (dither_mode)
//
// A write item is taken without holding off the next item. For a map item, the one
// distance unit compares one palette entry per cycle, fed by the single read port of the
// palette memory, through three pipeline stages and a hand-off.
// Reset clears control state and dither_mode; the palette holds no value until written.
// A result waits in the output register while out is stalled; a further result
// holds the search unit, and in stays stalled, until that register is free.
`include "assert_macros.svh"

module ordered_dither_palette_mapper_unit #(
    parameter int PALETTE_ENTRIES = odpm_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [odpm_pkg::CHAN_W-1:0]     entry_index,
    input  logic [odpm_pkg::CHAN_W-1:0]     red,
    input  logic [odpm_pkg::CHAN_W-1:0]     green,
    input  logic [odpm_pkg::CHAN_W-1:0]     blue,
    input  logic [1:0]                      column_phase,
    input  logic [1:0]                      row_phase,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [odpm_pkg::OUT_W-1:0]      palette_index,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data
);
    import odpm_pkg::*;

    logic dither_mode_reg;
    logic out_valid_reg;
    logic [OUT_W-1:0] palette_index_reg;
    logic accept;
    logic in_range;
    logic take;
    odpm_req_t req;
    odpm_stat_t stat;
    logic [OUT_W-1:0] result;

    // Decode the accepted item
    assign accept = in_valid && !in_stall;
    assign in_range = ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));

    always_comb
    begin
        req.start = accept && (opcode == OP_MAP);
        req.wr_en = accept && (opcode == OP_WRITE) && in_range;
        req.wr_addr = entry_index;
        req.wr_word = {red[7:2], green[7:2], blue[7:2]};
        req.r6 = dither_six(red, column_phase, row_phase, dither_mode_reg);
        req.g6 = dither_six(green, column_phase, row_phase, dither_mode_reg);
        req.b6 = dither_six(blue, column_phase, row_phase, dither_mode_reg);
    end

    odpm_search #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .take   (take),
        .stat   (stat),
        .result (result)
    );

    // Hold off new items while a search runs or waits
    assign in_stall = stat.busy;

    // Move the result into the output register once it is free
    assign take = stat.done && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dither_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dither_mode_reg <= cfg_wr_data;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            palette_index_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign palette_index = palette_index_reg;

    `ODPM_ASSERT(a_map_starts, (accept && opcode == OP_MAP) |=> stat.busy, "map item did not start a search")
    `ODPM_ASSERT(a_write_no_search, (accept && opcode == OP_WRITE) |=> !stat.busy, "write item started a search")
    `ODPM_ASSERT(a_out_from_search, $rose(out_valid_reg) |-> $past(stat.done), "result appeared without a search")
    `ODPM_ASSERT(a_result_waits, (out_valid_reg && out_stall && stat.done) |=> stat.done, "pending result dropped")

endmodule

// ===== test/odpm_nearest_color_checker.sv =====
module odpm_nearest_color_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [1:0]  column_phase,
    input  logic [1:0]  row_phase,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  palette_index,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    output int          mismatches,
    output int          results_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import odpm_pkg::*;

    localparam int ENTRIES = PALETTE_ENTRIES_DEFAULT;
    localparam int CHANNEL_TOP = 255;
    localparam int PRINT_CAP = 100;
    // Threshold offsets, indexed by column phase then row phase
    localparam int BAYER_OFFSET [4][4] = '{
        '{-7,  1, -5,  3},
        '{ 5, -3,  7, -1},
        '{-4,  4, -6,  2},
        '{ 8,  0,  6, -2}
    };

    typedef struct packed {
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] b;
    } rgb6_t;

    rgb6_t      palette_copy [ENTRIES];
    logic       dither_on = 1'b0;
    logic [7:0] nearest_due [$];
    int         mismatch_count = 0;
    int         pending = 0;

    assign mismatches  = mismatch_count;
    assign results_due = pending;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            palette_copy[i] = '0;
        end
    end

    // Add the threshold offset when enabled, clamp, keep the top six bits
    function automatic logic [5:0] to_six(input logic [7:0] chan, input int offset,
                                          input logic mode);
        int v;
        v = chan;
        if (mode) begin
            v = v + offset;
            if (v < 0) v = 0;
            if (v > CHANNEL_TOP) v = CHANNEL_TOP;
        end
        return 6'(v >> 2);
    endfunction

    // Search the whole palette; strict less-than keeps the lowest index on a tie
    function automatic logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic [1:0] col,
                                                 input logic [1:0] row);
        rgb6_t      px;
        int         off;
        int         dr;
        int         dg;
        int         db;
        int         sq_dist;
        int         best_dist;
        logic [7:0] best;
        off = BAYER_OFFSET[col][row];
        px.r = to_six(r, off, dither_on);
        px.g = to_six(g, off, dither_on);
        px.b = to_six(b, off, dither_on);
        best = '0;
        best_dist = 32'h7fff_ffff;
        for (int c = 0; c < ENTRIES; c++) begin
            dr = int'(palette_copy[c].r) - int'(px.r);
            dg = int'(palette_copy[c].g) - int'(px.g);
            db = int'(palette_copy[c].b) - int'(px.b);
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best_dist) begin
                best_dist = sq_dist;
                best = 8'(c);
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("%0t ns mismatch: %s (expected %0d, got %0d)", $time, what, want, got);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            dither_on = 1'b0;
            nearest_due.delete();
        end else begin
            // Take a register write
            if (cfg_wr_en) begin
                dither_on = cfg_wr_data;
            end
            // Compare a delivered result with the oldest prediction
            if (out_valid && !out_stall) begin
                if (nearest_due.size() == 0) begin
                    report_mismatch("palette_index with no item outstanding", -1,
                                    palette_index);
                end else begin
                    if (palette_index !== nearest_due[0]) begin
                        report_mismatch("palette_index", nearest_due[0], palette_index);
                    end
                    void'(nearest_due.pop_front());
                end
            end
            // Apply an accepted item
            if (in_valid && !in_stall) begin
                if (opcode == OP_WRITE) begin
                    if (entry_index < ENTRIES) begin
                        palette_copy[entry_index] = '{to_six(red, 0, 1'b0),
                                                      to_six(green, 0, 1'b0),
                                                      to_six(blue, 0, 1'b0)};
                    end
                end else begin
                    nearest_due.push_back(nearest_entry(red, green, blue,
                                                        column_phase, row_phase));
                end
            end
        end
        pending = nearest_due.size();
    end

endmodule

// ===== test/tb_ordered_dither_palette_mapper_unit.sv =====
module tb_ordered_dither_palette_mapper_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import odpm_pkg::*;

    localparam int ENTRIES = PALETTE_ENTRIES_DEFAULT;
    localparam int SETTLE_CYCLES = ENTRIES + 40;
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASES = 6;
    localparam int LONG_HOLD_CYCLES = 1500;
    localparam logic DITHER_OFF = 1'b0;
    localparam logic DITHER_ON = 1'b1;
    localparam logic [23:0] TIE_COLOR = 24'h40_80_C0;
    localparam logic PHASE_MODE [PHASES] = '{DITHER_ON, DITHER_OFF, DITHER_ON,
                                             DITHER_ON, DITHER_OFF, DITHER_ON};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       opcode = OP_WRITE;
    logic [7:0] entry_index = '0;
    logic [7:0] red = '0;
    logic [7:0] green = '0;
    logic [7:0] blue = '0;
    logic [1:0] column_phase = '0;
    logic [1:0] row_phase = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] palette_index;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;

    int mismatches;
    int results_due;
    bit calm = 1'b0;
    int hold_request = 0;
    int cycle_count = 0;

    ordered_dither_palette_mapper_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .entry_index  (entry_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .column_phase (column_phase),
        .row_phase    (row_phase),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .palette_index(palette_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    odpm_nearest_color_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .entry_index  (entry_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .column_phase (column_phase),
        .row_phase    (row_phase),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .palette_index(palette_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mismatches   (mismatches),
        .results_due  (results_due)
    );

    always #10 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold when requested
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request != 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one item, with an optional gap before it, and hold it until taken
    task automatic offer(input logic op, input logic [7:0] idx, input logic [7:0] r,
                         input logic [7:0] g, input logic [7:0] b, input logic [1:0] col,
                         input logic [1:0] row);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        entry_index  <= idx;
        red          <= r;
        green        <= g;
        blue         <= b;
        column_phase <= col;
        row_phase    <= row;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline empty
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_dither(input logic mode);
        @(negedge clk);
        cfg_wr_data <= mode;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Favor channel values near the clamp limits a quarter of the time
    function automatic logic [7:0] pick_channel();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1) ? 8'($urandom_range(247, 255))
                                        : 8'($urandom_range(0, 8));
        end
        return 8'($urandom);
    endfunction

    // Fill every entry; the coarse set repeats few colors so ties are common
    task automatic load_palette(input bit coarse);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int i = 0; i < ENTRIES; i++) begin
            if (coarse) begin
                r = 8'($urandom_range(0, 3) * 85);
                g = 8'($urandom_range(0, 3) * 85);
                b = 8'($urandom_range(0, 3) * 85);
            end else begin
                r = pick_channel();
                g = pick_channel();
                b = pick_channel();
                if (i == 0) {r, g, b} = 24'h00_00_00;
                if (i == ENTRIES - 1) {r, g, b} = 24'hFF_FF_FF;
                if (i == 100 || i == 200) {r, g, b} = TIE_COLOR;
            end
            offer(OP_WRITE, 8'(i), r, g, b, 2'($urandom), 2'($urandom));
        end
    endtask

    task automatic random_item();
        logic op;
        op = ($urandom_range(0, 9) < 7) ? OP_MAP : OP_WRITE;
        offer(op, 8'($urandom), pick_channel(), pick_channel(), pick_channel(),
              2'($urandom), 2'($urandom));
    endtask

    initial begin
        // Hold reset, then release it away from the active edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_dither(DITHER_OFF);
        load_palette(1'b0);

        // Plain nearest color: extremes, an exact duplicate, a rewritten entry
        offer(OP_MAP, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 2'd0);
        offer(OP_MAP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 2'd3);
        offer(OP_MAP, 8'h5A, TIE_COLOR[23:16], TIE_COLOR[15:8], TIE_COLOR[7:0], 2'd1, 2'd2);
        offer(OP_WRITE, 8'hFF, 8'hFF, 8'h00, 8'hFF, 2'd2, 2'd1);
        offer(OP_MAP, 8'hA5, 8'hFF, 8'h00, 8'hFF, 2'd0, 2'd3);

        // Dithered: clamp at both ends and offsets of both signs
        settle_block();
        set_dither(DITHER_ON);
        offer(OP_MAP, 8'h00, 8'h03, 8'h03, 8'h03, 2'd0, 2'd0);
        offer(OP_MAP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 2'd0);
        offer(OP_MAP, 8'h12, 8'hFA, 8'h05, 8'h80, 2'd3, 2'd0);
        offer(OP_MAP, 8'h34, 8'h00, 8'hFF, 8'h00, 2'd1, 2'd2);
        offer(OP_MAP, 8'h56, 8'h01, 8'hFE, 8'h07, 2'd2, 2'd2);
        offer(OP_MAP, 8'h78, TIE_COLOR[23:16], TIE_COLOR[15:8], TIE_COLOR[7:0], 2'd3, 2'd1);
        offer(OP_WRITE, 8'h00, 8'h04, 8'h04, 8'h04, 2'd3, 2'd3);
        offer(OP_MAP, 8'h9A, 8'h00, 8'h00, 8'h00, 2'd0, 2'd0);
        offer(OP_MAP, 8'hBC, 8'h7F, 8'h80, 8'h81, 2'd1, 2'd1);

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            settle_block();
            set_dither(PHASE_MODE[p]);
            if (p == 2) hold_request = LONG_HOLD_CYCLES;
            if (p == 3) load_palette(1'b1);
            if (p == PHASES - 1) calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_item();
                if (p == 1 && i == PHASE_ITEMS / 2) begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (results_due != 0) @(negedge clk);
                end
            end
        end

        settle_block();
        if (mismatches == 0 && results_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
